@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the mailbox RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is asserted (active low)
`define DMBX_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dmbx assertion failed");

// Clocked assertion that also holds during reset
`define DMBX_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dmbx assertion failed");

`else

`define DMBX_ASSERT(lbl, clk, rst_n, prop)
`define DMBX_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ rtl/dmbx_pkg.sv @@
// ---------------------------------------------------------------------------
// dmbx_pkg
// Types and constants shared by the dual mailbox modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmbx_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned ValidB  = 15;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned UserW   = 4;
  localparam int unsigned OutW    = 24;

  localparam logic [WordW-1:0] HighDataMask = 16'h7FFF;
  localparam logic [WordW-1:0] ValidMask    = 16'h8000;

  // Mailbox commands
  typedef enum logic [CmdW-1:0] {
    CMD_WR_HIGH = 2'd0,
    CMD_WR_LOW  = 2'd1,
    CMD_RD_HIGH = 2'd2,
    CMD_RD_LOW  = 2'd3
  } cmd_e;

  // One access steered to a single mailbox
  typedef struct packed {
    logic             en;
    cmd_e             cmd;
    logic             receiver;  // access made by the receiving side
    logic [WordW-1:0] data;
  } access_t;

endpackage

@@ rtl/dmbx_box.sv @@
// ---------------------------------------------------------------------------
// dmbx_box
// One 32-bit mailbox: high word with valid flag, low word, read snapshot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmbx_box (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dmbx_pkg::access_t            acc_i,
  output logic [dmbx_pkg::WordW-1:0]   rd_data_o,  // zero for writes
  output logic                         full_o      // valid flag after access
);

  logic [dmbx_pkg::WordW-1:0] high_q, high_d;
  logic [dmbx_pkg::WordW-1:0] low_q, low_d;
  logic [dmbx_pkg::WordW-1:0] snap_q, snap_d;
  logic                       held_q, held_d;

  // Next-state and read data
  always_comb begin
    high_d    = high_q;
    low_d     = low_q;
    snap_d    = snap_q;
    held_d    = held_q;
    rd_data_o = '0;
    if (acc_i.en) begin
      case (acc_i.cmd)
        dmbx_pkg::CMD_WR_HIGH: begin
          high_d = acc_i.data & dmbx_pkg::HighDataMask;
        end
        dmbx_pkg::CMD_WR_LOW: begin
          low_d  = acc_i.data;
          high_d = high_q | dmbx_pkg::ValidMask;
        end
        dmbx_pkg::CMD_RD_HIGH: begin
          rd_data_o = high_q;
          held_d    = high_q[dmbx_pkg::ValidB];
          if (high_q[dmbx_pkg::ValidB]) begin
            snap_d = low_q;
          end
        end
        dmbx_pkg::CMD_RD_LOW: begin
          rd_data_o = held_q ? snap_q : low_q;
          held_d    = 1'b0;
          // only the receiving side consumes the message
          if (acc_i.receiver) begin
            high_d = high_q & dmbx_pkg::HighDataMask;
          end
        end
        default: begin
          rd_data_o = '0;
        end
      endcase
    end
  end

  assign full_o = high_d[dmbx_pkg::ValidB];

  // Mailbox state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= '0;
      low_q  <= '0;
      snap_q <= '0;
      held_q <= 1'b0;
    end else begin
      high_q <= high_d;
      low_q  <= low_d;
      snap_q <= snap_d;
      held_q <= held_d;
    end
  end

  // Assertions
  `DMBX_ASSERT(a_wr_low_sets_valid, clk_i, rst_ni,
    (acc_i.en && acc_i.cmd == dmbx_pkg::CMD_WR_LOW) |=> high_q[dmbx_pkg::ValidB])
  `DMBX_ASSERT(a_wr_high_clears_valid, clk_i, rst_ni,
    (acc_i.en && acc_i.cmd == dmbx_pkg::CMD_WR_HIGH) |=> !high_q[dmbx_pkg::ValidB])
  `DMBX_ASSERT(a_rd_low_drops_snap, clk_i, rst_ni,
    (acc_i.en && acc_i.cmd == dmbx_pkg::CMD_RD_LOW) |=> !held_q)
  `DMBX_ASSERT(a_idle_holds_state, clk_i, rst_ni,
    !acc_i.en |=> ($stable(high_q) && $stable(low_q) && $stable(held_q)))

endmodule

@@ rtl/dual_mailbox_with_snapshot_core.sv @@
// ---------------------------------------------------------------------------
// dual_mailbox_with_snapshot_core
// Host-to-DSP and DSP-to-host 32-bit mailboxes behind a stream interface.
// ---------------------------------------------------------------------------
// Usage:
//   Each input word on the s_axis channel is one mailbox access: tuser says
//   which command, which mailbox and which side makes it; tdata carries the
//   write word. Every access returns exactly one word on m_axis with the read
//   word (zero for writes) and both mailbox full flags after the access.
//   An accepted access sits in the input register; when it advances, the
//   mailbox is updated and the result register is loaded, which raises
//   m_axis_tvalid. Throughput is one word per cycle while the receiver keeps
//   m_axis_tready high; the mailbox update is a single register-to-register
//   step, so back-to-back accesses to the same mailbox see each other's
//   effects.
//   Reset clears both mailboxes, their snapshots and both pipeline valid flags.
//   When the receiver stalls (m_axis_tready low), the result word holds, the
//   input register keeps one more word and s_axis_tready then drops until
//   the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_mailbox_with_snapshot_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // access stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dmbx_pkg::WordW-1:0]    s_axis_tdata,  // [15:0] write_data
  input  logic [dmbx_pkg::UserW-1:0]    s_axis_tuser,  // [1:0] command, [2] box_select,
                                                       // [3] from_dsp
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dmbx_pkg::OutW-1:0]     m_axis_tdata   // [15:0] read_data,
                                                       // [16] to_dsp_full,
                                                       // [17] to_host_full, rest 0
);

  logic                       in_valid_q;
  logic [dmbx_pkg::WordW-1:0] in_data_q;
  dmbx_pkg::cmd_e             in_cmd_q;
  logic                       in_sel_q;
  logic                       in_dsp_q;
  logic                       out_valid_q;
  logic [dmbx_pkg::OutW-1:0]  out_data_q, out_data_d;
  logic                       advance;

  dmbx_pkg::access_t          acc_dsp, acc_host;
  logic [dmbx_pkg::WordW-1:0] rd_dsp, rd_host;
  logic                       full_dsp, full_host;

  // Pipeline control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_cmd_q  <= dmbx_pkg::cmd_e'(s_axis_tuser[1:0]);
      in_sel_q  <= s_axis_tuser[2];
      in_dsp_q  <= s_axis_tuser[3];
    end
  end

  // Steer the access to one mailbox; the receiver of box 0 is the DSP
  always_comb begin
    acc_dsp.en        = advance && !in_sel_q;
    acc_dsp.cmd       = in_cmd_q;
    acc_dsp.receiver  = in_dsp_q;
    acc_dsp.data      = in_data_q;
    acc_host.en       = advance && in_sel_q;
    acc_host.cmd      = in_cmd_q;
    acc_host.receiver = !in_dsp_q;
    acc_host.data     = in_data_q;
  end

  dmbx_box u_box_to_dsp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc_dsp),
    .rd_data_o (rd_dsp),
    .full_o    (full_dsp)
  );

  dmbx_box u_box_to_host (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc_host),
    .rd_data_o (rd_host),
    .full_o    (full_host)
  );

  // Result word
  assign out_data_d = {6'b0, full_host, full_dsp, (in_sel_q ? rd_host : rd_dsp)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Assertions
  `DMBX_ASSERT(a_held_item_stays, clk_i, rst_ni,
    (in_valid_q && !advance) |=> in_valid_q)
  `DMBX_ASSERT(a_result_loaded, clk_i, rst_ni,
    advance |=> m_axis_tvalid)
  `DMBX_ASSERT(a_flags_match_boxes, clk_i, rst_ni,
    advance |=> (m_axis_tdata[16] == $past(full_dsp) &&
                 m_axis_tdata[17] == $past(full_host)))
  `DMBX_ASSERT_ALWAYS(a_one_box_per_access, clk_i,
    !(acc_dsp.en && acc_host.en))

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the dual mailbox with read snapshot. A queue of
// mailbox accesses (directed corner cases, then random transfers and noise)
// feeds a bursty stream driver. A monitor predicts each reply from its own
// copy of both mailboxes and checks every result word against it while the
// result side stalls on a changing pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dmbx_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 1950;

  // One mailbox access as queued for the driver
  typedef struct packed {
    logic             from_dsp;
    logic             box;
    cmd_e             cmd;
    logic [WordW-1:0] wdata;
  } mbx_access_t;

  // One reply word split into its fields
  typedef struct packed {
    logic [OutW-WordW-3:0] pad;
    logic                  host_full;
    logic                  dsp_full;
    logic [WordW-1:0]      rdata;
  } mbx_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [WordW-1:0] s_axis_tdata  = '0;
  logic [UserW-1:0] s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;

  dual_mailbox_with_snapshot_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mbx_access_t pend_q[$];
  mbx_reply_t  reply_q[$];

  // Predicted mailbox contents, index 0 host-to-DSP, 1 DSP-to-host
  logic [WordW-1:0] box_hi[2];
  logic [WordW-1:0] box_lo[2];
  logic [WordW-1:0] box_snap[2];
  logic             box_snap_held[2];

  int unsigned err_cnt     = 0;
  int unsigned queued_cnt  = 0;
  int unsigned checked_cnt = 0;
  int unsigned snap_hits   = 0;
  int unsigned cmd_cnt[4]  = '{0, 0, 0, 0};
  int unsigned cycle_cnt   = 0;
  logic        in_taken    = 1'b0;

  // Apply one access to the predicted mailboxes and return the reply
  function automatic mbx_reply_t mailbox_access(mbx_access_t a);
    mbx_reply_t r;
    logic       rx_side;
    r = '0;
    case (a.cmd)
      CMD_WR_HIGH: begin
        box_hi[a.box] = a.wdata & HighDataMask;
      end
      CMD_WR_LOW: begin
        box_lo[a.box] = a.wdata;
        box_hi[a.box] = box_hi[a.box] | ValidMask;
      end
      CMD_RD_HIGH: begin
        r.rdata = box_hi[a.box];
        box_snap_held[a.box] = box_hi[a.box][ValidB];
        if (box_hi[a.box][ValidB]) box_snap[a.box] = box_lo[a.box];
      end
      CMD_RD_LOW: begin
        if (box_snap_held[a.box]) begin
          r.rdata = box_snap[a.box];
          snap_hits++;
        end else begin
          r.rdata = box_lo[a.box];
        end
        box_snap_held[a.box] = 1'b0;
        // only the receiving side clears valid
        rx_side = (a.box == 1'b0) ? a.from_dsp : !a.from_dsp;
        if (rx_side) box_hi[a.box] = box_hi[a.box] & HighDataMask;
      end
      default: ;
    endcase
    r.dsp_full  = box_hi[0][ValidB];
    r.host_full = box_hi[1][ValidB];
    cmd_cnt[a.cmd]++;
    return r;
  endfunction

  task automatic queue_access(cmd_e cmd, logic box, logic from_dsp, logic [WordW-1:0] wdata);
    mbx_access_t a;
    a.cmd      = cmd;
    a.box      = box;
    a.from_dsp = from_dsp;
    a.wdata    = wdata;
    pend_q.push_back(a);
    queued_cnt++;
  endtask

  task automatic queue_noise();
    queue_access(cmd_e'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // One well-formed transfer through a mailbox, with random twists
  task automatic queue_transfer(logic box);
    logic sender;
    logic receiver;
    sender   = box;  // host sends in box 0, DSP sends in box 1
    receiver = !box;
    if ($urandom_range(0, 9) != 0) begin
      queue_access(CMD_WR_HIGH, box, sender, 16'($urandom));
      if ($urandom_range(0, 6) == 0) queue_noise();
    end
    queue_access(CMD_WR_LOW, box, sender, 16'($urandom));
    if ($urandom_range(0, 6) == 0) queue_noise();
    if ($urandom_range(0, 6) != 0) begin
      queue_access(CMD_RD_HIGH, box, receiver, 16'($urandom));
      // sender overwrites low word while a snapshot is held
      if ($urandom_range(0, 3) == 0) queue_access(CMD_WR_LOW, box, sender, 16'($urandom));
    end
    if ($urandom_range(0, 7) == 0) queue_access(CMD_RD_LOW, box, sender, 16'($urandom));
    if ($urandom_range(0, 9) != 0) queue_access(CMD_RD_LOW, box, receiver, 16'($urandom));
    if ($urandom_range(0, 6) == 0) queue_noise();
  endtask

  // Stimulus, reset and end of run
  initial begin
    for (int i = 0; i < 2; i++) begin
      box_hi[i]        = '0;
      box_lo[i]        = '0;
      box_snap[i]      = '0;
      box_snap_held[i] = 1'b0;
    end

    // directed corner cases
    queue_access(CMD_RD_LOW,  1'b0, 1'b1, 16'h0000);  // fresh mailbox, no snapshot
    queue_access(CMD_RD_HIGH, 1'b1, 1'b0, 16'hFFFF);  // read high, valid clear
    queue_access(CMD_WR_HIGH, 1'b0, 1'b0, 16'hFFFF);  // bit 15 masked off
    queue_access(CMD_WR_LOW,  1'b0, 1'b0, 16'hFFFF);
    queue_access(CMD_RD_HIGH, 1'b0, 1'b1, 16'h0000);  // takes snapshot
    queue_access(CMD_WR_LOW,  1'b0, 1'b0, 16'h0000);  // live word moves on
    queue_access(CMD_RD_LOW,  1'b0, 1'b0, 16'h0000);  // sender read: snapshot, valid kept
    queue_access(CMD_RD_LOW,  1'b0, 1'b1, 16'hFFFF);  // receiver read: live word, clears
    queue_access(CMD_WR_HIGH, 1'b1, 1'b0, 16'h0000);  // write by the non-sending side
    queue_access(CMD_WR_LOW,  1'b1, 1'b0, 16'hA5A5);
    queue_access(CMD_RD_HIGH, 1'b1, 1'b0, 16'h0000);
    queue_access(CMD_RD_LOW,  1'b1, 1'b0, 16'h0000);
    queue_access(CMD_RD_HIGH, 1'b1, 1'b0, 16'h0000);  // valid clear, no snapshot taken
    queue_access(CMD_RD_LOW,  1'b1, 1'b1, 16'h0000);
    queue_access(CMD_WR_HIGH, 1'b1, 1'b1, 16'h5A5A);
    queue_access(CMD_WR_LOW,  1'b1, 1'b1, 16'h0000);
    queue_access(CMD_RD_HIGH, 1'b1, 1'b0, 16'h0000);
    queue_access(CMD_RD_LOW,  1'b1, 1'b1, 16'h0000);  // sender read leaves valid
    queue_access(CMD_RD_HIGH, 1'b1, 1'b0, 16'h0000);
    queue_access(CMD_RD_LOW,  1'b1, 1'b0, 16'h0000);
    queue_access(CMD_WR_HIGH, 1'b0, 1'b1, 16'h8000);
    queue_access(CMD_WR_LOW,  1'b0, 1'b1, 16'h1234);
    queue_access(CMD_RD_HIGH, 1'b0, 1'b1, 16'h0000);
    queue_access(CMD_RD_LOW,  1'b0, 1'b1, 16'h0000);

    // random transfers with some noise in between
    while (queued_cnt < RandomItems + 24) begin
      if ($urandom_range(0, 3) == 0) queue_noise();
      else queue_transfer(1'($urandom));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d replies for %0d accesses (wr_hi %0d, wr_lo %0d, rd_hi %0d, rd_lo %0d)",
             checked_cnt, queued_cnt, cmd_cnt[CMD_WR_HIGH], cmd_cnt[CMD_WR_LOW],
             cmd_cnt[CMD_RD_HIGH], cmd_cnt[CMD_RD_LOW]);
    $display("low-word reads served from a snapshot: %0d, mismatches: %0d", snap_hits, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: run limit reached, %0d words still pending", $time, pend_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Access driver: bursts of random length with random gaps
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) pend_q.delete(0);
      if (s_axis_tvalid && !in_taken) begin
        // hold the current word
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pend_q[0].wdata;
        s_axis_tuser  <= {pend_q[0].from_dsp, pend_q[0].box, pend_q[0].cmd};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result-side stall pattern: always ready, random, or long stall runs
  int unsigned rx_mode    = 0;
  int unsigned phase_left = 0;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    logic rdy;
    if (phase_left == 0) begin
      rx_mode    = $urandom_range(0, 2);
      phase_left = $urandom_range(50, 300);
    end else begin
      phase_left--;
    end
    case (rx_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
    m_axis_tready <= rdy;
  end

  // Monitor: predict on each accepted access, check each result word
  always @(posedge clk_i) begin
    mbx_access_t acc;
    mbx_reply_t  got;
    mbx_reply_t  want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        acc.wdata    = s_axis_tdata;
        acc.cmd      = cmd_e'(s_axis_tuser[1:0]);
        acc.box      = s_axis_tuser[2];
        acc.from_dsp = s_axis_tuser[3];
        reply_q.push_back(mailbox_access(acc));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (reply_q.size() == 0) begin
          err_cnt++;
          $display("%0t: expected no result word, got %h", $time, got);
        end else begin
          want = reply_q.pop_front();
          checked_cnt++;
          if (got.rdata !== want.rdata || got.dsp_full !== want.dsp_full ||
              got.host_full !== want.host_full || got.pad !== want.pad) begin
            err_cnt++;
            $display("%0t: reply mismatch: expected rd %h dsp_full %b host_full %b pad %h,",
                     $time, want.rdata, want.dsp_full, want.host_full, want.pad,
                     " got rd %h dsp_full %b host_full %b pad %h",
                     got.rdata, got.dsp_full, got.host_full, got.pad);
          end
        end
      end
    end
  end

endmodule
